// ===== design/rae_pkg.sv =====
// ----------------------------------------------------------------------------
// rae_pkg: shared definitions for the register ALU instruction executor
// Opcodes, status codes, cycle costs and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rae_pkg;

    // default register file depth
    localparam int NUM_REGS_DEF = 16;

    // serial divider steps, one quotient bit each
    localparam int DIV_STEPS = 32;

    // opcodes, odd codes take the right operand as an immediate
    localparam logic [7:0] OP_LOAD   = 8'd0;
    localparam logic [7:0] OP_ADD_RR = 8'd16;
    localparam logic [7:0] OP_ADD_RI = 8'd17;
    localparam logic [7:0] OP_SUB_RR = 8'd32;
    localparam logic [7:0] OP_SUB_RI = 8'd33;
    localparam logic [7:0] OP_MUL_RR = 8'd48;
    localparam logic [7:0] OP_MUL_RI = 8'd49;
    localparam logic [7:0] OP_DIV_RR = 8'd64;
    localparam logic [7:0] OP_DIV_RI = 8'd65;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;
    localparam logic [1:0] ST_DIVZERO = 2'd3;

    // weighted cycle costs
    localparam logic [2:0] COST_NONE = 3'd0;
    localparam logic [2:0] COST_ALU  = 3'd1;
    localparam logic [2:0] COST_MUL  = 3'd2;
    localparam logic [2:0] COST_DIV  = 3'd4;

    // controller to datapath commands
    typedef struct packed {
        logic cap;   // capture item, read both source registers
        logic exec;  // evaluate, charge counters, load divider
        logic step;  // one divider step
        logic fin;   // write back and load the output register
    } rae_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_go;  // divide with no error, run the divider
    } rae_sts_t;

endpackage

// ===== design/rae_ctrl.sv =====
// ----------------------------------------------------------------------------
// rae_ctrl: instruction sequencer
// Accepts one item, steps it through evaluate, divide (error-free divides only)
// and write-back, and owns the result valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rae_ctrl
    import rae_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output rae_cmd_t cmd,
    input  rae_sts_t sts
);

    localparam int CW = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_FIN
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   cnt_reg;
    logic            mval_reg;

    // decode commands from the current state
    always_comb begin
        s_ready  = (state_reg == S_IDLE);
        cmd.cap  = s_valid && (state_reg == S_IDLE);
        cmd.exec = (state_reg == S_EXEC);
        cmd.step = (state_reg == S_DIV);
        cmd.fin  = (state_reg == S_FIN) && (!mval_reg || m_ready);
    end

    assign m_valid = mval_reg;

    // hold state, divider count and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            mval_reg  <= 1'b0;
        end else begin
            if (cmd.fin) begin
                mval_reg <= 1'b1;
            end else if (m_ready) begin
                mval_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    cnt_reg <= '0;
                    if (sts.div_go) begin
                        state_reg <= S_DIV;
                    end else begin
                        state_reg <= S_FIN;
                    end
                end
                S_DIV: begin
                    if (cnt_reg == CW'(DIV_STEPS - 1)) begin
                        state_reg <= S_FIN;
                    end else begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                S_FIN: begin
                    if (cmd.fin) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/rae_dp.sv =====
// ----------------------------------------------------------------------------
// rae_dp: executor datapath
// Register file, operand decode, add/sub/multiply, serial signed divider,
// instruction and cycle counters and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rae_dp
    import rae_pkg::*;
#(
    parameter int NUM_REGS = NUM_REGS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [7:0]         s_opcode,
    input  logic [7:0]         s_dest_reg,
    input  logic [7:0]         s_left_operand,
    input  logic [7:0]         s_right_operand,
    input  rae_cmd_t           cmd,
    output rae_sts_t           sts,
    output logic [3:0]         m_written_reg,
    output logic signed [31:0] m_written_value,
    output logic               m_did_write,
    output logic [1:0]         m_status,
    output logic [31:0]        m_cycle_total,
    output logic [31:0]        m_instr_count
);

    localparam int         AW      = $clog2(NUM_REGS);
    localparam logic [8:0] NregLim = 9'(NUM_REGS);

    // captured instruction
    logic [7:0]  op_reg, d_reg, lo_reg, ro_reg;
    // register file and registered read ports
    logic [31:0]         mem [NUM_REGS];
    logic [NUM_REGS-1:0] vld_reg;
    logic [31:0]         rda_reg, rdb_reg;
    // evaluation results
    logic [1:0]  stat_reg;
    logic [31:0] res_reg;
    logic        isdiv_reg;
    // divider
    logic        negq_reg;
    logic [31:0] dvs_reg, quo_reg, rem_reg;
    // counters
    logic [31:0] cyc_reg, ins_reg;
    // output register
    logic [3:0]  wreg_reg;
    logic [31:0] wval_reg;
    logic        did_reg;
    logic [1:0]  ost_reg;
    logic [31:0] otot_reg, ocnt_reg;

    logic        is_load, is_add, is_sub, is_mul, is_div, known, imm;
    logic        d_ok, lo_ok, ro_ok, idx_err;
    logic [31:0] a_op, b_op, prod, res_c, fin_val;
    logic [1:0]  stat_c;
    logic [2:0]  cost_c;
    logic [32:0] trial;
    logic        fit;

    // decode the captured opcode and check indices
    always_comb begin
        is_load = (op_reg == OP_LOAD);
        is_add  = (op_reg == OP_ADD_RR) || (op_reg == OP_ADD_RI);
        is_sub  = (op_reg == OP_SUB_RR) || (op_reg == OP_SUB_RI);
        is_mul  = (op_reg == OP_MUL_RR) || (op_reg == OP_MUL_RI);
        is_div  = (op_reg == OP_DIV_RR) || (op_reg == OP_DIV_RI);
        known   = is_load || is_add || is_sub || is_mul || is_div;
        imm     = op_reg[0];
        d_ok    = {1'b0, d_reg} < NregLim;
        lo_ok   = {1'b0, lo_reg} < NregLim;
        ro_ok   = {1'b0, ro_reg} < NregLim;
        idx_err = is_load ? !d_ok : !(d_ok && lo_ok && (imm || ro_ok));
    end

    // operands, one multiplier and the result select
    assign a_op = rda_reg;
    assign b_op = imm ? {24'b0, ro_reg} : rdb_reg;
    assign prod = a_op * b_op;

    always_comb begin
        if (is_load) begin
            res_c = {24'b0, lo_reg};
        end else if (is_add) begin
            res_c = a_op + b_op;
        end else if (is_sub) begin
            res_c = a_op - b_op;
        end else begin
            res_c = prod;
        end

        if (!known) begin
            stat_c = ST_UNKNOWN;
        end else if (idx_err) begin
            stat_c = ST_RANGE;
        end else if (is_div && (b_op == 32'd0)) begin
            stat_c = ST_DIVZERO;
        end else begin
            stat_c = ST_OK;
        end

        if (!known) begin
            cost_c = COST_NONE;
        end else if (is_mul) begin
            cost_c = COST_MUL;
        end else if (is_div) begin
            cost_c = COST_DIV;
        end else begin
            cost_c = COST_ALU;
        end
    end

    assign sts.div_go = is_div && (stat_c == ST_OK);

    // one restoring division step on magnitudes
    assign trial = {rem_reg, quo_reg[31]};
    assign fit   = trial >= {1'b0, dvs_reg};

    // apply the quotient sign at write-back
    assign fin_val = isdiv_reg ? (negq_reg ? (32'd0 - quo_reg) : quo_reg) : res_reg;

    // capture the item and read both source registers, write back on finish
    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            op_reg  <= s_opcode;
            d_reg   <= s_dest_reg;
            lo_reg  <= s_left_operand;
            ro_reg  <= s_right_operand;
            rda_reg <= vld_reg[s_left_operand[AW-1:0]] ? mem[s_left_operand[AW-1:0]] : 32'd0;
            rdb_reg <= vld_reg[s_right_operand[AW-1:0]] ? mem[s_right_operand[AW-1:0]]
                                                         : 32'd0;
        end
        if (cmd.fin && (stat_reg == ST_OK)) begin
            mem[d_reg[AW-1:0]] <= fin_val;
        end
    end

    // mark written entries, unwritten ones read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (cmd.fin && (stat_reg == ST_OK)) begin
            vld_reg[d_reg[AW-1:0]] <= 1'b1;
        end
    end

    // charge the cycle and instruction counters on evaluate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cyc_reg <= '0;
            ins_reg <= '0;
        end else if (cmd.exec) begin
            cyc_reg <= cyc_reg + {29'b0, cost_c};
            ins_reg <= ins_reg + 32'd1;
        end
    end

    // hold the evaluation result and load the divider on evaluate, advance it one bit per step
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            stat_reg  <= stat_c;
            res_reg   <= res_c;
            isdiv_reg <= is_div;
            negq_reg  <= a_op[31] ^ (!imm && b_op[31]);
            quo_reg   <= a_op[31] ? (32'd0 - a_op) : a_op;
            dvs_reg   <= (!imm && b_op[31]) ? (32'd0 - b_op) : b_op;
            rem_reg   <= '0;
        end else if (cmd.step) begin
            rem_reg <= fit ? 32'(trial - {1'b0, dvs_reg}) : trial[31:0];
            quo_reg <= {quo_reg[30:0], fit};
        end
    end

    // load the output register
    always_ff @(posedge aclk) begin
        if (cmd.fin) begin
            did_reg  <= (stat_reg == ST_OK);
            wreg_reg <= (stat_reg == ST_OK) ? d_reg[3:0] : 4'd0;
            wval_reg <= (stat_reg == ST_OK) ? fin_val : 32'd0;
            ost_reg  <= stat_reg;
            otot_reg <= cyc_reg + 32'd1;
            ocnt_reg <= ins_reg;
        end
    end

    assign m_written_reg   = wreg_reg;
    assign m_written_value = wval_reg;
    assign m_did_write     = did_reg;
    assign m_status        = ost_reg;
    assign m_cycle_total   = otot_reg;
    assign m_instr_count   = ocnt_reg;

endmodule

// ===== design/register_alu_instruction_executor.sv =====
// ----------------------------------------------------------------------------
// register_alu_instruction_executor: register file ALU instruction executor
// Sequence: accept, evaluate, divide (divides only, 32-step divider), write-back
// into the output register. One item at a time; the next item is
// taken while the previous result waits in the output register.
// Reset: synchronous, active low; clears control, counters and register file valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module register_alu_instruction_executor
    import rae_pkg::*;
#(
    parameter int NUM_REGS = NUM_REGS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_opcode,
    input  logic [7:0]         s_dest_reg,
    input  logic [7:0]         s_left_operand,
    input  logic [7:0]         s_right_operand,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_written_reg,
    output logic signed [31:0] m_written_value,
    output logic               m_did_write,
    output logic [1:0]         m_status,
    output logic [31:0]        m_cycle_total,
    output logic [31:0]        m_instr_count
);

    rae_cmd_t cmd;
    rae_sts_t sts;

    // sequencer
    rae_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // datapath
    rae_dp #(
        .NUM_REGS (NUM_REGS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_opcode        (s_opcode),
        .s_dest_reg      (s_dest_reg),
        .s_left_operand  (s_left_operand),
        .s_right_operand (s_right_operand),
        .cmd             (cmd),
        .sts             (sts),
        .m_written_reg   (m_written_reg),
        .m_written_value (m_written_value),
        .m_did_write     (m_did_write),
        .m_status        (m_status),
        .m_cycle_total   (m_cycle_total),
        .m_instr_count   (m_instr_count)
    );

endmodule

// ===== design/rae_chk.sv =====
// ----------------------------------------------------------------------------
// rae_chk: port checker for the executor
// Watches handshakes and result consistency on the top level ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rae_chk
    import rae_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [3:0]  m_written_reg,
    input logic [31:0] m_written_value,
    input logic        m_did_write,
    input logic [1:0]  m_status,
    input logic [31:0] m_cycle_total,
    input logic [31:0] m_instr_count
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_written_value)
            && $stable(m_status) && $stable(m_instr_count) && $stable(m_cycle_total))
        else $error("result changed while stalled");

    // one item at a time: accept closes the input
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input stayed open after accept");

    // a write is only reported with an ok status
    a_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_did_write |-> m_status == ST_OK)
        else $error("write reported with error status");

    // no write: index and value are zero and status shows an error
    a_nowr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_did_write |-> m_written_reg == 4'd0 && m_written_value == 32'd0
            && m_status != ST_OK)
        else $error("inconsistent result without write");

endmodule

bind register_alu_instruction_executor rae_chk u_rae_chk (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_written_reg   (m_written_reg),
    .m_written_value (m_written_value),
    .m_did_write     (m_did_write),
    .m_status        (m_status),
    .m_cycle_total   (m_cycle_total),
    .m_instr_count   (m_instr_count)
);
